/* rtl/i2cra_pkg.sv */
// Shared types and codes for the I2C register access master.
// No dependencies; used by the interface and the top level.
`timescale 1ns / 1ps

package i2cra_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // One input word: a tick or a command.
  typedef struct packed {
    logic [1:0]  operation;
    logic [6:0]  dev_addr;
    logic [15:0] sub_addr;
    logic        sub_two_bytes;
    logic [7:0]  wr_data;
    logic        sda_in;
  } in_t;

  // One result word: line drives and status after the item.
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rd_data;
    logic       ack_missing;
  } out_t;

endpackage

/* rtl/i2cra_stream_if.sv */
// Valid/ready channel carrying one payload word.
// Payload type is a parameter; typically a struct from i2cra_pkg.
`timescale 1ns / 1ps

interface i2cra_stream_if #(
  parameter type payload_t = i2cra_pkg::in_t
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/i2c_master_register_access_top.sv */
// I2C master for single-register write and read transactions.
// The result word for an accepted item is held in the output register.
// Throughput: one item per cycle unless results back up; the output register
// lets a new item in while the previous result is taken in the same cycle.
// Reset (rst, synchronous): sequencer idle, both lines released high,
// received byte and ack flag cleared, result register empty.
`timescale 1ns / 1ps

module i2c_master_register_access_top (
  input  logic               clk,
  input  logic               rst,
  i2cra_stream_if.sink       in_ch,
  i2cra_stream_if.source     out_ch
);

  // Transaction steps. Each step runs a few quarter-bit phases on ticks.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'd0,
    ST_START1 = 4'd1,
    ST_ADDRW  = 4'd2,
    ST_SUBHI  = 4'd3,
    ST_SUBLO  = 4'd4,
    ST_DATA   = 4'd5,
    ST_START2 = 4'd6,
    ST_ADDRR  = 4'd7,
    ST_RECV   = 4'd8,
    ST_NACK   = 4'd9,
    ST_STOP   = 4'd10
  } step_t;

  // Sequencer state
  step_t       step;
  logic [2:0]  phase;
  logic [2:0]  bit_idx;
  logic [7:0]  shift_byte;
  logic [7:0]  received_byte;
  logic [6:0]  latched_addr;
  logic [15:0] latched_sub;
  logic        flag_read;
  logic        flag_two;
  logic [7:0]  latched_wdata;
  logic        nack_seen;
  logic        scl;
  logic        sda;

  step_t       step_next;
  logic [2:0]  phase_next;
  logic [2:0]  bit_idx_next;
  logic [7:0]  shift_byte_next;
  logic [7:0]  received_byte_next;
  logic [6:0]  latched_addr_next;
  logic [15:0] latched_sub_next;
  logic        flag_read_next;
  logic        flag_two_next;
  logic [7:0]  latched_wdata_next;
  logic        nack_seen_next;
  logic        scl_next;
  logic        sda_next;
  logic        done_next;

  // Result register
  logic                 out_valid;
  i2cra_pkg::out_t      out_word;

  logic                 accept;
  i2cra_pkg::in_t       item;
  logic                 advance;   // leave current step
  step_t                target;

  // Step order; branches use the latched flags.
  function automatic step_t next_after(input step_t s, input logic rd, input logic two);
    step_t r;
    case (s)
      ST_START1: r = ST_ADDRW;
      ST_ADDRW:  r = two ? ST_SUBHI : ST_SUBLO;
      ST_SUBHI:  r = ST_SUBLO;
      ST_SUBLO:  r = rd ? ST_START2 : ST_DATA;
      ST_DATA:   r = ST_STOP;
      ST_START2: r = ST_ADDRR;
      ST_ADDRR:  r = ST_RECV;
      ST_RECV:   r = ST_NACK;
      ST_NACK:   r = ST_STOP;
      default:   r = ST_IDLE;
    endcase
    return r;
  endfunction

  // Output register empties when taken, so input flows while it is empty or taken.
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign item        = in_ch.data;

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_word;

  always_comb begin
    step_next          = step;
    phase_next         = phase;
    bit_idx_next       = bit_idx;
    shift_byte_next    = shift_byte;
    received_byte_next = received_byte;
    latched_addr_next  = latched_addr;
    latched_sub_next   = latched_sub;
    flag_read_next     = flag_read;
    flag_two_next      = flag_two;
    latched_wdata_next = latched_wdata;
    nack_seen_next     = nack_seen;
    scl_next           = scl;
    sda_next           = sda;
    done_next          = 1'b0;
    advance            = 1'b0;
    target             = ST_IDLE;

    if (step == ST_IDLE) begin
      // Command latches operands only; bus moves on the next tick.
      if (item.operation == i2cra_pkg::OP_WRITE || item.operation == i2cra_pkg::OP_READ) begin
        latched_addr_next  = item.dev_addr;
        latched_sub_next   = item.sub_addr;
        flag_read_next     = (item.operation == i2cra_pkg::OP_READ);
        flag_two_next      = item.sub_two_bytes;
        latched_wdata_next = item.wr_data;
        nack_seen_next     = 1'b0;
        advance            = 1'b1;
        target             = ST_START1;
      end
    end else if (item.operation == i2cra_pkg::OP_TICK) begin
      case (step)
        ST_START1, ST_START2: begin
          case (phase)
            3'd0: begin sda_next = 1'b1; phase_next = 3'd1; end
            3'd1: begin scl_next = 1'b1; phase_next = 3'd2; end
            3'd2: begin sda_next = 1'b0; phase_next = 3'd3; end
            default: begin
              scl_next = 1'b0;
              advance  = 1'b1;
              target   = next_after(step, flag_read, flag_two);
            end
          endcase
        end
        ST_ADDRW, ST_SUBHI, ST_SUBLO, ST_DATA, ST_ADDRR: begin
          case (phase)
            3'd0: begin
              scl_next   = 1'b0;
              sda_next   = shift_byte[3'd7 - bit_idx];
              phase_next = 3'd1;
            end
            3'd1: begin
              scl_next = 1'b1;
              if (bit_idx != 3'd7) begin
                bit_idx_next = bit_idx + 3'd1;
                phase_next   = 3'd0;
              end else begin
                phase_next = 3'd2;
              end
            end
            3'd2: begin scl_next = 1'b0; phase_next = 3'd3; end
            3'd3: begin sda_next = 1'b1; phase_next = 3'd4; end
            3'd4: begin scl_next = 1'b1; phase_next = 3'd5; end
            default: begin
              // ack slot: high level means no acknowledge (sticky)
              if (item.sda_in) nack_seen_next = 1'b1;
              scl_next = 1'b0;
              advance  = 1'b1;
              target   = next_after(step, flag_read, flag_two);
            end
          endcase
        end
        ST_RECV: begin
          case (phase)
            3'd0: begin
              if (bit_idx == 3'd0) sda_next = 1'b1;
              phase_next = 3'd1;
            end
            3'd1: begin scl_next = 1'b0; phase_next = 3'd2; end
            3'd2: begin scl_next = 1'b1; phase_next = 3'd3; end
            3'd3: begin
              shift_byte_next = {shift_byte[6:0], item.sda_in};
              if (bit_idx != 3'd7) begin
                bit_idx_next = bit_idx + 3'd1;
                phase_next   = 3'd0;
              end else begin
                phase_next = 3'd4;
              end
            end
            default: begin
              scl_next           = 1'b0;
              received_byte_next = shift_byte;
              advance            = 1'b1;
              target             = next_after(step, flag_read, flag_two);
            end
          endcase
        end
        ST_NACK: begin
          case (phase)
            3'd0: begin sda_next = 1'b1; phase_next = 3'd1; end
            3'd1: begin scl_next = 1'b1; phase_next = 3'd2; end
            default: begin
              scl_next = 1'b0;
              advance  = 1'b1;
              target   = next_after(step, flag_read, flag_two);
            end
          endcase
        end
        ST_STOP: begin
          case (phase)
            3'd0: begin sda_next = 1'b0; phase_next = 3'd1; end
            3'd1: begin scl_next = 1'b1; phase_next = 3'd2; end
            default: begin
              sda_next  = 1'b1;
              done_next = 1'b1;
              advance   = 1'b1;
              target    = ST_IDLE;
            end
          endcase
        end
        default: begin
          // unreachable code: back to idle
          advance = 1'b1;
          target  = ST_IDLE;
        end
      endcase
    end

    // Step entry: clear counters, load the byte to send.
    if (advance) begin
      step_next    = target;
      phase_next   = 3'd0;
      bit_idx_next = 3'd0;
      case (target)
        ST_ADDRW: shift_byte_next = {latched_addr_next, 1'b0};
        ST_SUBHI: shift_byte_next = latched_sub_next[15:8];
        ST_SUBLO: shift_byte_next = latched_sub_next[7:0];
        ST_DATA:  shift_byte_next = latched_wdata_next;
        ST_ADDRR: shift_byte_next = {latched_addr_next, 1'b1};
        ST_RECV:  shift_byte_next = 8'd0;
        default:  shift_byte_next = shift_byte_next;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= ST_IDLE;
      phase         <= 3'd0;
      bit_idx       <= 3'd0;
      shift_byte    <= 8'd0;
      received_byte <= 8'd0;
      latched_addr  <= 7'd0;
      latched_sub   <= 16'd0;
      flag_read     <= 1'b0;
      flag_two      <= 1'b0;
      latched_wdata <= 8'd0;
      nack_seen     <= 1'b0;
      scl           <= 1'b1;
      sda           <= 1'b1;
      out_valid     <= 1'b0;
      out_word      <= '0;
    end else begin
      if (accept) begin
        step          <= step_next;
        phase         <= phase_next;
        bit_idx       <= bit_idx_next;
        shift_byte    <= shift_byte_next;
        received_byte <= received_byte_next;
        latched_addr  <= latched_addr_next;
        latched_sub   <= latched_sub_next;
        flag_read     <= flag_read_next;
        flag_two      <= flag_two_next;
        latched_wdata <= latched_wdata_next;
        nack_seen     <= nack_seen_next;
        scl           <= scl_next;
        sda           <= sda_next;
        out_word.scl_out     <= scl_next;
        out_word.sda_out     <= sda_next;
        out_word.busy_res    <= (step_next != ST_IDLE);
        out_word.done_res    <= done_next;
        out_word.rd_data     <= received_byte_next;
        out_word.ack_missing <= nack_seen_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* sim/tb_i2c_master_register_access_top.sv */
// Self-checking testbench for i2c_master_register_access_top.
// Needs rtl/i2cra_pkg.sv and rtl/i2cra_stream_if.sv; drives the command channel and
// checks every result word against a cycle-free bus sequencer model kept in the bench.
`timescale 1ns / 1ps

module tb_i2c_master_register_access_top;

  // operation code 3 is not a defined command; the block must ignore it
  localparam logic [1:0] OP_BAD = 2'd3;
  // run stops here even if the block hangs
  localparam int CYCLE_LIMIT = 400000;
  // clock edges waited after the last expected result before the verdict
  localparam int TAIL_CYCLES = 20;
  // words that move the bus, per idle mode of the random part
  localparam int RANDOM_WORDS_PER_MODE = 170;

  // bench copy of the sequencer steps
  typedef enum logic [3:0] {
    S_IDLE, S_START1, S_ADDRW, S_SUBHI, S_SUBLO, S_DATA,
    S_START2, S_ADDRR, S_RECV, S_NACK, S_STOP
  } step_t;

  logic clk = 1'b0;
  logic rst;

  i2cra_stream_if #(.payload_t(i2cra_pkg::in_t))  cmd_ch ();
  i2cra_stream_if #(.payload_t(i2cra_pkg::out_t)) res_ch ();

  i2c_master_register_access_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (cmd_ch),
    .out_ch (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Bus sequencer model state (bench side)
  // ---------------------------------------------------------------------------
  step_t       m_step;
  logic [2:0]  m_phase;
  logic [2:0]  m_bit;
  logic [7:0]  m_shift;
  logic [7:0]  m_rx_byte;
  logic [6:0]  l_addr;
  logic [15:0] l_sub;
  logic        l_read;
  logic        l_two;
  logic [7:0]  l_wdata;
  logic        m_nack;
  logic        m_scl;
  logic        m_sda;
  bit          m_moved;   // last word advanced or started something

  i2cra_pkg::out_t expected_lines[$];

  int snd_idle_pct;
  int rcv_idle_pct;
  int moved_words;
  int mismatches;
  int cycles;

  function automatic step_t step_after(step_t s);
    case (s)
      S_START1: return S_ADDRW;
      S_ADDRW:  return l_two ? S_SUBHI : S_SUBLO;
      S_SUBHI:  return S_SUBLO;
      S_SUBLO:  return l_read ? S_START2 : S_DATA;
      S_DATA:   return S_STOP;
      S_START2: return S_ADDRR;
      S_ADDRR:  return S_RECV;
      S_RECV:   return S_NACK;
      S_NACK:   return S_STOP;
      default:  return S_IDLE;
    endcase
  endfunction

  // entering a step reloads the shifter with the byte that step sends
  function automatic void enter_step(step_t s);
    m_step  = s;
    m_phase = 3'd0;
    m_bit   = 3'd0;
    case (s)
      S_ADDRW: m_shift = {l_addr, 1'b0};
      S_SUBHI: m_shift = l_sub[15:8];
      S_SUBLO: m_shift = l_sub[7:0];
      S_DATA:  m_shift = l_wdata;
      S_ADDRR: m_shift = {l_addr, 1'b1};
      S_RECV:  m_shift = 8'h00;
      default: ;
    endcase
  endfunction

  function automatic void bus_model_reset();
    m_step    = S_IDLE;
    m_phase   = 3'd0;
    m_bit     = 3'd0;
    m_shift   = 8'h00;
    m_rx_byte = 8'h00;
    l_addr    = 7'h00;
    l_sub     = 16'h0000;
    l_read    = 1'b0;
    l_two     = 1'b0;
    l_wdata   = 8'h00;
    m_nack    = 1'b0;
    m_scl     = 1'b1;
    m_sda     = 1'b1;
  endfunction

  // One accepted word in, the line drives and status it leaves behind out.
  function automatic i2cra_pkg::out_t i2c_bus_step(i2cra_pkg::in_t w);
    i2cra_pkg::out_t r;
    logic done;
    done    = 1'b0;
    m_moved = 1'b0;
    if (m_step == S_IDLE) begin
      // a command only latches; the bus starts moving on the next tick
      if (w.operation == i2cra_pkg::OP_WRITE || w.operation == i2cra_pkg::OP_READ) begin
        l_addr  = w.dev_addr;
        l_sub   = w.sub_addr;
        l_read  = (w.operation == i2cra_pkg::OP_READ);
        l_two   = w.sub_two_bytes;
        l_wdata = w.wr_data;
        m_nack  = 1'b0;
        enter_step(S_START1);
        m_moved = 1'b1;
      end
    end else if (w.operation == i2cra_pkg::OP_TICK) begin
      // commands and code 3 while busy fall through untouched
      m_moved = 1'b1;
      case (m_step)
        S_START1, S_START2: begin
          case (m_phase)
            3'd0: begin m_sda = 1'b1; m_phase = 3'd1; end
            3'd1: begin m_scl = 1'b1; m_phase = 3'd2; end
            3'd2: begin m_sda = 1'b0; m_phase = 3'd3; end
            default: begin m_scl = 1'b0; enter_step(step_after(m_step)); end
          endcase
        end
        S_ADDRW, S_SUBHI, S_SUBLO, S_DATA, S_ADDRR: begin
          case (m_phase)
            3'd0: begin
              m_scl   = 1'b0;
              m_sda   = m_shift[3'd7 - m_bit];
              m_phase = 3'd1;
            end
            3'd1: begin
              m_scl = 1'b1;
              if (m_bit < 3'd7) begin
                m_bit   = m_bit + 3'd1;
                m_phase = 3'd0;
              end else begin
                m_phase = 3'd2;
              end
            end
            3'd2: begin m_scl = 1'b0; m_phase = 3'd3; end
            3'd3: begin m_sda = 1'b1; m_phase = 3'd4; end
            3'd4: begin m_scl = 1'b1; m_phase = 3'd5; end
            default: begin
              // ack slot: a high line is a missing ack, sticky until next command
              if (w.sda_in) m_nack = 1'b1;
              m_scl = 1'b0;
              enter_step(step_after(m_step));
            end
          endcase
        end
        S_RECV: begin
          case (m_phase)
            3'd0: begin
              if (m_bit == 3'd0) m_sda = 1'b1;
              m_phase = 3'd1;
            end
            3'd1: begin m_scl = 1'b0; m_phase = 3'd2; end
            3'd2: begin m_scl = 1'b1; m_phase = 3'd3; end
            3'd3: begin
              m_shift = {m_shift[6:0], w.sda_in};
              if (m_bit < 3'd7) begin
                m_bit   = m_bit + 3'd1;
                m_phase = 3'd0;
              end else begin
                m_phase = 3'd4;
              end
            end
            default: begin
              m_scl     = 1'b0;
              m_rx_byte = m_shift;
              enter_step(step_after(m_step));
            end
          endcase
        end
        S_NACK: begin
          case (m_phase)
            3'd0: begin m_sda = 1'b1; m_phase = 3'd1; end
            3'd1: begin m_scl = 1'b1; m_phase = 3'd2; end
            default: begin m_scl = 1'b0; enter_step(step_after(m_step)); end
          endcase
        end
        S_STOP: begin
          case (m_phase)
            3'd0: begin m_sda = 1'b0; m_phase = 3'd1; end
            3'd1: begin m_scl = 1'b1; m_phase = 3'd2; end
            default: begin
              m_sda = 1'b1;
              enter_step(S_IDLE);
              done = 1'b1;
            end
          endcase
        end
        default: enter_step(S_IDLE);
      endcase
    end
    r.scl_out     = m_scl;
    r.sda_out     = m_sda;
    r.busy_res    = (m_step != S_IDLE);
    r.done_res    = done;
    r.rd_data     = m_rx_byte;
    r.ack_missing = m_nack;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // every field random; callers overwrite what matters
  function automatic i2cra_pkg::in_t random_word(logic [1:0] op);
    i2cra_pkg::in_t w;
    w.operation     = op;
    w.dev_addr      = 7'($urandom_range(127));
    w.sub_addr      = 16'($urandom_range(65535));
    w.sub_two_bytes = 1'($urandom_range(1));
    w.wr_data       = 8'($urandom_range(255));
    w.sda_in        = 1'($urandom_range(1));
    return w;
  endfunction

  // next tick lands on an ack sample of a sent byte
  function automatic bit at_ack_slot();
    return (m_step inside {S_ADDRW, S_SUBHI, S_SUBLO, S_DATA, S_ADDRR}) && (m_phase == 3'd5);
  endfunction

  // Present one word, hold it until taken, then run it through the model.
  // Prediction happens here so the model state is current when the caller
  // builds the next word.
  task automatic send_word(i2cra_pkg::in_t w);
    while ($urandom_range(99) < snd_idle_pct) begin
      @(negedge clk);
      cmd_ch.valid <= 1'b0;
    end
    @(negedge clk);
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= w;
    do @(posedge clk); while (!(cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1));
    expected_lines.push_back(i2c_bus_step(w));
    if (m_moved) moved_words++;
  endtask

  // sender holds off until every expected word has come back
  task automatic drain_results();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
  endtask

  // One command followed by ticks until the model goes idle.
  // nack_pct biases the ack slots; noise_pct mixes in commands and code 3
  // while busy, which must not move the bus.
  task automatic run_transaction(logic [1:0] op, logic [6:0] dev, logic [15:0] sub,
                                 logic two, logic [7:0] wdata, int nack_pct,
                                 int noise_pct);
    i2cra_pkg::in_t w;
    int  pick;
    w               = random_word(op);
    w.dev_addr      = dev;
    w.sub_addr      = sub;
    w.sub_two_bytes = two;
    w.wr_data       = wdata;
    send_word(w);
    while (m_step != S_IDLE) begin
      if ($urandom_range(99) < noise_pct) begin
        pick = $urandom_range(2);
        w = random_word(pick == 0 ? i2cra_pkg::OP_WRITE :
                        (pick == 1 ? i2cra_pkg::OP_READ : OP_BAD));
      end else begin
        w = random_word(i2cra_pkg::OP_TICK);
        if (at_ack_slot()) w.sda_in = ($urandom_range(99) < nack_pct);
      end
      send_word(w);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // ticks and code 3 out of reset: lines stay released, nothing latches
  task automatic test_idle_words();
    i2cra_pkg::in_t w;
    w = random_word(i2cra_pkg::OP_TICK);
    w.sda_in = 1'b0;
    send_word(w);
    w.sda_in = 1'b1;
    send_word(w);
    send_word(random_word(OP_BAD));
    send_word(random_word(i2cra_pkg::OP_TICK));
    drain_results();
  endtask

  // all-ones operands with acks, then all-zero operands with every ack missing
  task automatic test_write_extremes();
    run_transaction(i2cra_pkg::OP_WRITE, 7'h7F, 16'hFFFF, 1'b1, 8'hFF, 0, 0);
    run_transaction(i2cra_pkg::OP_WRITE, 7'h00, 16'h0000, 1'b0, 8'h00, 100, 0);
    drain_results();
  endtask

  // both subaddress lengths on reads; received byte comes from random sda bits
  task automatic test_read_paths();
    run_transaction(i2cra_pkg::OP_READ, 7'h7F, 16'hFFFF, 1'b1, 8'h00, 0, 0);
    run_transaction(i2cra_pkg::OP_READ, 7'h00, 16'h0000, 1'b0, 8'hFF, 100, 0);
    drain_results();
  endtask

  // commands and code 3 landing mid-transaction must be dropped; a write
  // after a read keeps the received byte
  task automatic test_busy_commands();
    run_transaction(i2cra_pkg::OP_READ, 7'h55, 16'hA55A, 1'b1, 8'h5A, 30, 20);
    run_transaction(i2cra_pkg::OP_WRITE, 7'h2A, 16'h5AA5, 1'b0, 8'hA5, 30, 20);
    drain_results();
  endtask

  // random transactions with a little idle noise in between
  task automatic run_random_phase(int snd_pct, int rcv_pct);
    int target;
    int n;
    int nack_pct;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    target = moved_words + RANDOM_WORDS_PER_MODE;
    while (moved_words < target) begin
      // idle-time junk: ticks and code 3 do nothing
      n = $urandom_range(3) == 0 ? $urandom_range(1, 3) : 0;
      repeat (n) send_word(random_word($urandom_range(1) ? i2cra_pkg::OP_TICK : OP_BAD));
      case ($urandom_range(3))
        0:       nack_pct = 0;
        1:       nack_pct = 100;
        default: nack_pct = 15;
      endcase
      run_transaction($urandom_range(1) ? i2cra_pkg::OP_READ : i2cra_pkg::OP_WRITE,
                      7'($urandom_range(127)), 16'($urandom_range(65535)),
                      1'($urandom_range(1)), 8'($urandom_range(255)),
                      nack_pct, $urandom_range(1) ? 0 : 5);
    end
    drain_results();
  endtask

  task automatic test_random();
    run_random_phase(12, 58);
    run_random_phase(58, 12);
    run_random_phase(0, 0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side and checking
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    i2cra_pkg::out_t exp_w;
    i2cra_pkg::out_t got_w;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      got_w = res_ch.data;
      if (expected_lines.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: scl=%0b sda=%0b busy=%0b done=%0b rd=%02h nack=%0b",
                   got_w.scl_out, got_w.sda_out, got_w.busy_res, got_w.done_res,
                   got_w.rd_data, got_w.ack_missing);
      end else begin
        exp_w = expected_lines.pop_front();
        if (got_w.scl_out !== exp_w.scl_out || got_w.sda_out !== exp_w.sda_out ||
            got_w.busy_res !== exp_w.busy_res || got_w.done_res !== exp_w.done_res ||
            got_w.rd_data !== exp_w.rd_data || got_w.ack_missing !== exp_w.ack_missing) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: exp scl=%0b sda=%0b busy=%0b done=%0b rd=%02h nack=%0b",
                     $realtime, exp_w.scl_out, exp_w.sda_out, exp_w.busy_res,
                     exp_w.done_res, exp_w.rd_data, exp_w.ack_missing);
          if (mismatches <= 10)
            $display("                  got scl=%0b sda=%0b busy=%0b done=%0b rd=%02h nack=%0b",
                     got_w.scl_out, got_w.sda_out, got_w.busy_res, got_w.done_res,
                     got_w.rd_data, got_w.ack_missing);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("i2c_master_register_access_top verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    snd_idle_pct = 12;
    rcv_idle_pct = 58;
    moved_words  = 0;
    bus_model_reset();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_words();
    test_write_extremes();
    test_read_paths();
    test_busy_commands();
    test_random();

    // everything has come back; wait TAIL_CYCLES longer for stray words
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("i2c_master_register_access_top verification clean");
    end else begin
      $display("i2c_master_register_access_top verification failed");
    end
    $finish;
  end

endmodule
